FILE: src/swm_pkg.sv
// Shared types and sizing constants for the sliding-window maximum filter.
// No dependencies; used by the channel interfaces and imported by every module.
`default_nettype none

package swm_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_W       = 7;                         // window_size register width
  localparam int FILL_W      = $clog2(MAX_WINDOW + 1);    // fill count, 0..MAX_WINDOW
  localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CMP_W       = (WIN_W > FILL_W) ? WIN_W : FILL_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [WIN_W-1:0]       win_t;
  typedef logic        [FILL_W-1:0]      fill_t;
  typedef logic        [IDX_W-1:0]       idx_t;
  typedef logic        [CMP_W-1:0]       wcmp_t;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic shift;    // a transaction was accepted: every cell loads
    logic restart;  // start of sequence: every cell drops its history
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/swm_if.sv
// Valid/ready channel interfaces for the sliding-window maximum filter:
// sample input, result output and window_size write port. Uses swm_pkg.
`default_nettype none

interface swm_in_if;
  logic              valid;
  logic              ready;
  swm_pkg::sample_t  sample;
  logic              start_of_sequence;

  modport source (output valid, output sample, output start_of_sequence, input ready);
  modport sink   (input valid, input sample, input start_of_sequence, output ready);
endinterface

interface swm_out_if;
  logic              valid;
  logic              ready;
  swm_pkg::sample_t  window_max;

  modport source (output valid, output window_max, input ready);
  modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if;
  logic              valid;
  logic              ready;
  swm_pkg::win_t     window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

FILE: src/sliding_window_maximum.sv
// Sliding-window maximum filter, top level.
// Depends on swm_pkg, swm_if (channel interfaces) and swm_chain.
//
// Usage:
//   in_ch  : one signed sample per transaction, with start_of_sequence,
//            which discards all earlier samples before this one is taken.
//   out_ch : window_max, the maximum of the last window_size samples. A
//            result follows every sample once window_size samples have
//            arrived since the last start of sequence; earlier samples give
//            none. Samples dropped by a smaller window stay out of later
//            results even if the window grows again.
//   cfg_ch : writes window_size (0 acts as 1, above 64 acts as 64). Always
//            ready; write only while no sample is in flight.
// Output: a result is valid the cycle after its sample is accepted.
// Throughput: one sample per cycle while out_ch accepts; each cell of the
//   64-cell chain does one compare per sample; the tap picks the live span.
// Reset: window_size returns to 1, the fill count and live span to zero, no
//   result pending.
// Stall: the result register holds while out_ch.ready is low; a new sample
//   is still accepted in the cycle the pending result is taken.
`default_nettype none

module sliding_window_maximum (
  input  wire  clk,
  input  wire  rst_n,
  swm_in_if.sink    in_ch,
  swm_out_if.source out_ch,
  swm_cfg_if.sink   cfg_ch
);
  import swm_pkg::*;

  win_t       win_r;
  fill_t      fill_r, fill_nxt;
  fill_t      live_r, live_nxt;
  wcmp_t      live_inc;
  logic       out_valid_r, out_valid_nxt;
  sample_t    out_data_r;
  wcmp_t      win_ext, w_eff;
  idx_t       sel_idx;
  sample_t    sel_max;
  cell_ctrl_t ctrl;
  logic       accept;
  logic       emit;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  assign ctrl.shift   = accept;
  assign ctrl.restart = in_ch.start_of_sequence;

  // effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    win_ext = CMP_W'(win_r);
    if (win_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
      w_eff = CMP_W'(MAX_WINDOW);
    end else begin
      w_eff = win_ext;
    end
  end

  // live span: newest samples still eligible; a shrink drops the rest for good
  always_comb begin
    live_inc = CMP_W'(live_r) + CMP_W'(1);
    if (in_ch.start_of_sequence) begin
      live_nxt = FILL_W'(1);
    end else if (live_inc > w_eff) begin
      live_nxt = FILL_W'(w_eff);
    end else begin
      live_nxt = FILL_W'(live_inc);
    end
  end

  assign sel_idx = IDX_W'(live_nxt - FILL_W'(1));

  swm_chain u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .new_sample (in_ch.sample),
    .sel_idx    (sel_idx),
    .sel_max    (sel_max)
  );

  // fill count saturates at MAX_WINDOW so it never wraps back below the window
  always_comb begin
    if (in_ch.start_of_sequence) begin
      fill_nxt = FILL_W'(1);
    end else if (fill_r == FILL_W'(MAX_WINDOW)) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  assign emit = CMP_W'(fill_nxt) >= w_eff;

  always_comb begin
    if (accept) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WIN_W'(1);
      fill_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        win_r <= cfg_ch.window_size;
      end
      if (accept) begin
        fill_r <= fill_nxt;
        live_r <= live_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= sel_max;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.window_max = out_data_r;

`ifndef SYNTHESIS
  // a fresh sequence with a one-sample window returns the sample itself
  a_restart_unit_window : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.start_of_sequence && w_eff == CMP_W'(1))
      |=> (out_valid_r && out_data_r == $past(in_ch.sample)))
    else $error("unit window after restart did not return the sample");

  // the window always contains the newest sample
  a_max_covers_sample : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit) |=> (out_valid_r && out_data_r >= $past(in_ch.sample)))
    else $error("window maximum below the newest sample");

  // a restart with a longer window yields no result
  a_restart_no_result : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.start_of_sequence && w_eff > CMP_W'(1)) |=> !out_valid_r)
    else $error("result emitted before the window filled");
`endif

endmodule

`default_nettype wire

FILE: src/swm_cell.sv
// One cell of the running-maximum chain: holds the maximum of the samples
// from age 0 up to its own index. Uses swm_pkg.
`default_nettype none

module swm_cell (
  input  wire                  clk,
  input  swm_pkg::cell_ctrl_t  ctrl,
  input  swm_pkg::sample_t     new_sample,
  input  swm_pkg::sample_t     prev_max,    // left neighbor's stored maximum
  output swm_pkg::sample_t     max_r,
  output swm_pkg::sample_t     max_nxt
);
  import swm_pkg::*;

  always_comb begin
    if (ctrl.restart) begin
      max_nxt = new_sample;
    end else if (prev_max > new_sample) begin
      max_nxt = prev_max;
    end else begin
      max_nxt = new_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      max_r <= max_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/swm_chain.sv
// Row of MAX_WINDOW running-maximum cells plus the tap select for the
// current window length. Depends on swm_pkg and swm_cell.
`default_nettype none

module swm_chain (
  input  wire                  clk,
  input  swm_pkg::cell_ctrl_t  ctrl,
  input  swm_pkg::sample_t     new_sample,
  input  swm_pkg::idx_t        sel_idx,     // live span length minus one
  output swm_pkg::sample_t     sel_max
);
  import swm_pkg::*;

  sample_t cell_q   [MAX_WINDOW];
  sample_t cell_nxt [MAX_WINDOW];

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    if (g == 0) begin : g_head
      // age 0 only ever sees the new sample
      swm_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_sample (new_sample),
        .prev_max   (new_sample),
        .max_r      (cell_q[g]),
        .max_nxt    (cell_nxt[g])
      );
    end else begin : g_body
      swm_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_sample (new_sample),
        .prev_max   (cell_q[g-1]),
        .max_r      (cell_q[g]),
        .max_nxt    (cell_nxt[g])
      );
    end
  end

  // last cell's stored value has no reader; the tap works on next values
  assign sel_max = cell_nxt[sel_idx];

endmodule

`default_nettype wire
